>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros for the particle step block
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside of reset
`define PAS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define PAS_ASSERT_NR(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/pas_pkg.sv
// ---------------------------------------------------------------------------
// pas_pkg
// shared types and constants of the particle advect and sprite step block
// ---------------------------------------------------------------------------
package pas_pkg;

  // fixed point layout
  localparam int unsigned Q_FRAC     = 16;
  localparam int unsigned UNIT_SHIFT = 30;

  // pipeline depths
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 31;
  localparam int unsigned SIDE_DEPTH = SQRT_STEPS + DIV_STEPS;
  // input register, square, sum, root, divide, two multiplies, output
  localparam int unsigned PIPE_LAT   = 3 + SIDE_DEPTH + 3;

  // register indexes
  localparam logic [1:0] REG_GRID_COLUMNS = 2'd0;
  localparam logic [1:0] REG_GRID_ROWS    = 2'd1;
  localparam logic [1:0] REG_FRAME_PERIOD = 2'd2;

  // register reset values
  localparam logic [8:0]  COLS_RESET   = 9'd1;
  localparam logic [8:0]  ROWS_RESET   = 9'd1;
  localparam logic [31:0] PERIOD_RESET = 32'd6554;

  // unit length in Q1.30
  localparam logic [30:0] UNIT_ONE = 31'h4000_0000;

  typedef struct packed {
    logic [8:0]  grid_columns;
    logic [8:0]  grid_rows;
    logic [31:0] frame_period;
  } cfg_t;

  typedef struct packed {
    logic [31:0] elapsed;
    logic [31:0] tick;
    logic [7:0]  col;
    logic [7:0]  row;
  } anim_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] mag_abs;
    logic [31:0]      speed;
    logic [31:0]      dt;
    logic             zero;
    anim_t            anim;
  } side_t;

endpackage

>>> rtl/particle_advect_sprite_step_top.sv
// ---------------------------------------------------------------------------
// particle_advect_sprite_step_top
// radial particle position update with sprite sheet frame animation
// ---------------------------------------------------------------------------
// One particle word is taken on every cycle that start is high and busy is
// low (busy is high only during reset), and its updated word appears on the
// result ports, marked by a one-cycle done strobe. The pipeline holds the
// 32-stage square root and the 31-stage divider for the unit direction;
// new words can enter on every cycle, so the sustained rate is one particle
// per clock. Results cannot be held off by the receiver.
// Registers are written through cfg_wr/cfg_addr/cfg_data and should change
// only while no particle is in flight.
`include "assert_macros.svh"

module particle_advect_sprite_step_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_wr,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_data,
  input  logic        func,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic [31:0] speed,
  input  logic [31:0] elapsed,
  input  logic [31:0] life_limit,
  input  logic [31:0] frame_tick,
  input  logic [7:0]  frame_col,
  input  logic [7:0]  frame_row,
  input  logic [31:0] time_step,
  output logic        done,
  output logic [31:0] new_pos_x,
  output logic [31:0] new_pos_y,
  output logic [31:0] new_pos_z,
  output logic [31:0] new_elapsed,
  output logic [31:0] new_frame_tick,
  output logic [7:0]  new_frame_col,
  output logic [7:0]  new_frame_row
);
  import pas_pkg::*;

  logic             acc;
  cfg_t             cfg;

  logic             v1, v2, v3;
  logic [2:0][31:0] p1, abs1;
  logic [31:0]      sp1, dt1;
  logic             zero1;
  anim_t            anim1;
  logic [2:0][63:0] sq2;
  side_t            side2;
  logic [63:0]      sum3;
  side_t            sd [0:SIDE_DEPTH];

  logic             sq_vld;
  logic [31:0]      root;
  logic             dv_vld;
  logic [2:0][30:0] quo;

  logic             vm1, vm2;
  logic [2:0][31:0] vel;
  logic [2:0][47:0] travel;
  side_t            sm1, sm2;
  logic [2:0][31:0] pos_next;

  assign busy = rst;
  assign acc  = start & ~busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_columns <= COLS_RESET;
      cfg.grid_rows    <= ROWS_RESET;
      cfg.frame_period <= PERIOD_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_addr)
        REG_GRID_COLUMNS: cfg.grid_columns <= cfg_data[8:0];
        REG_GRID_ROWS:    cfg.grid_rows    <= cfg_data[8:0];
        REG_FRAME_PERIOD: cfg.frame_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // timers and sprite frame
  pas_anim u_anim (
    .clk        (clk),
    .vld_in     (acc),
    .cfg        (cfg),
    .func       (func),
    .elapsed    (elapsed),
    .life_limit (life_limit),
    .frame_tick (frame_tick),
    .frame_col  (frame_col),
    .frame_row  (frame_row),
    .time_step  (time_step),
    .anim       (anim1)
  );

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= acc;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // input register with magnitudes
  always_ff @(posedge clk) begin
    if (acc) begin
      p1[0]   <= pos_x;
      p1[1]   <= pos_y;
      p1[2]   <= pos_z;
      abs1[0] <= pos_x[31] ? (~pos_x + 32'd1) : pos_x;
      abs1[1] <= pos_y[31] ? (~pos_y + 32'd1) : pos_y;
      abs1[2] <= pos_z[31] ? (~pos_z + 32'd1) : pos_z;
      sp1     <= speed;
      dt1     <= time_step;
      zero1   <= (pos_x == 32'd0) && (pos_y == 32'd0) && (pos_z == 32'd0);
    end
  end

  // squares, then their sum
  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      sq2[l] <= {32'd0, abs1[l]} * {32'd0, abs1[l]};
    end
    side2.pos     <= p1;
    side2.mag_abs <= abs1;
    side2.speed   <= sp1;
    side2.dt      <= dt1;
    side2.zero    <= zero1;
    side2.anim    <= anim1;
    sum3          <= sq2[0] + sq2[1] + sq2[2];
    sd[0]         <= side2;
    for (int k = 1; k <= SIDE_DEPTH; k++) begin
      sd[k] <= sd[k-1];
    end
  end

  // vector length
  pas_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (v3),
    .sq_in   (sum3),
    .vld_out (sq_vld),
    .root    (root)
  );

  // unit direction components
  pas_div u_div (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (sq_vld),
    .mag     (root),
    .num     (sd[SQRT_STEPS].mag_abs),
    .vld_out (dv_vld),
    .quo     (quo)
  );

  // velocity, then distance over the time step
  always_ff @(posedge clk) begin
    logic [62:0] pv;
    logic [63:0] pd;
    for (int l = 0; l < 3; l++) begin
      pv     = {32'd0, quo[l]} * {31'd0, sd[SIDE_DEPTH].speed};
      vel[l] <= pv[UNIT_SHIFT+31:UNIT_SHIFT];
      pd     = {32'd0, vel[l]} * {32'd0, sm1.dt};
      travel[l] <= pd[63:Q_FRAC];
    end
    sm1 <= sd[SIDE_DEPTH];
    sm2 <= sm1;
  end

  // move along the sign of each axis with saturation
  always_comb begin
    logic [49:0] pe, de, rs;
    for (int l = 0; l < 3; l++) begin
      pe = {{18{sm2.pos[l][31]}}, sm2.pos[l]};
      de = {2'b00, travel[l]};
      rs = sm2.pos[l][31] ? pe - de : pe + de;
      if (sm2.zero) begin
        pos_next[l] = sm2.pos[l];
      end else if (!rs[49] && (rs[48:31] != 18'd0)) begin
        pos_next[l] = 32'h7FFF_FFFF;
      end else if (rs[49] && (rs[48:31] != 18'h3FFFF)) begin
        pos_next[l] = 32'h8000_0000;
      end else begin
        pos_next[l] = rs[31:0];
      end
    end
  end

  // back stage valid bits and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      vm1  <= 1'b0;
      vm2  <= 1'b0;
      done <= 1'b0;
    end else begin
      vm1  <= dv_vld;
      vm2  <= vm1;
      done <= vm2;
    end
    new_pos_x      <= pos_next[0];
    new_pos_y      <= pos_next[1];
    new_pos_z      <= pos_next[2];
    new_elapsed    <= sm2.anim.elapsed;
    new_frame_tick <= sm2.anim.tick;
    new_frame_col  <= sm2.anim.col;
    new_frame_row  <= sm2.anim.row;
  end

  // checks
  `PAS_ASSERT(a_done_latency, done |-> $past(start && !busy, PIPE_LAT), "done without accepted word")
  `PAS_ASSERT(a_root_zero, sq_vld |-> ((root == 32'd0) == sd[SQRT_STEPS].zero), "root zero mismatch")
  `PAS_ASSERT(a_unit_range, (dv_vld && !sd[SIDE_DEPTH].zero) |-> (quo[0] <= UNIT_ONE && quo[1] <= UNIT_ONE && quo[2] <= UNIT_ONE), "unit component above one")
  `PAS_ASSERT_NR(a_reset_clear, $past(rst) |-> !done, "done after reset")

endmodule

>>> rtl/pas_anim.sv
// ---------------------------------------------------------------------------
// pas_anim
// life timer, spark frame timer and sprite sheet frame step, one register
// ---------------------------------------------------------------------------
module pas_anim (
  input  logic           clk,
  input  logic           vld_in,
  input  pas_pkg::cfg_t  cfg,
  input  logic           func,
  input  logic [31:0]    elapsed,
  input  logic [31:0]    life_limit,
  input  logic [31:0]    frame_tick,
  input  logic [7:0]     frame_col,
  input  logic [7:0]     frame_row,
  input  logic [31:0]    time_step,
  output pas_pkg::anim_t anim
);
  import pas_pkg::*;

  logic [32:0] el_sum, tk_sum;
  logic [31:0] el_sat, tk_sat, el_new, tk_new;
  logic        adv;
  logic [8:0]  ecol, erow, ncol, nrow;
  anim_t       anim_next;

  // saturating timer sums
  assign el_sum = {1'b0, elapsed} + {1'b0, time_step};
  assign tk_sum = {1'b0, frame_tick} + {1'b0, time_step};
  assign el_sat = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
  assign tk_sat = tk_sum[32] ? 32'hFFFF_FFFF : tk_sum[31:0];

  // grid size clamped to 1..256
  assign ecol = (cfg.grid_columns == 9'd0) ? 9'd1 :
                (cfg.grid_columns > 9'd256) ? 9'd256 : cfg.grid_columns;
  assign erow = (cfg.grid_rows == 9'd0) ? 9'd1 :
                (cfg.grid_rows > 9'd256) ? 9'd256 : cfg.grid_rows;

  // mode decision and frame step
  always_comb begin
    if (func) begin
      adv    = tk_sat > cfg.frame_period;
      tk_new = adv ? 32'd0 : tk_sat;
      el_new = (el_sat >= life_limit) ? 32'd0 : el_sat;
    end else begin
      adv    = el_sat >= life_limit;
      tk_new = frame_tick;
      el_new = adv ? 32'd0 : el_sat;
    end
    ncol = {1'b0, frame_col};
    nrow = {1'b0, frame_row};
    if (adv) begin
      ncol = {1'b0, frame_col} + 9'd1;
      if (ncol >= ecol) begin
        ncol = 9'd0;
        nrow = {1'b0, frame_row} + 9'd1;
        if (nrow >= erow) begin
          nrow = 9'd0;
        end
      end
    end
    anim_next.elapsed = el_new;
    anim_next.tick    = tk_new;
    anim_next.col     = ncol[7:0];
    anim_next.row     = nrow[7:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (vld_in) begin
      anim <= anim_next;
    end
  end

endmodule

>>> rtl/pas_isqrt.sv
// ---------------------------------------------------------------------------
// pas_isqrt
// pipelined integer square root, one result bit per stage
// ---------------------------------------------------------------------------
module pas_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        vld_in,
  input  logic [63:0] sq_in,
  output logic        vld_out,
  output logic [31:0] root
);
  import pas_pkg::*;

  logic        vld      [0:SQRT_STEPS-1];
  logic [35:0] rem      [0:SQRT_STEPS-1];
  logic [31:0] rt       [0:SQRT_STEPS-1];
  logic [63:0] val      [0:SQRT_STEPS-1];
  logic [35:0] rem_next [0:SQRT_STEPS-1];
  logic [31:0] rt_next  [0:SQRT_STEPS-1];
  logic [63:0] val_next [0:SQRT_STEPS-1];

  // one digit step per stage
  always_comb begin
    logic [35:0] rs, trial, rin;
    logic [31:0] tin;
    logic [63:0] vin;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (k == 0) begin
        rin = 36'd0;
        tin = 32'd0;
        vin = sq_in;
      end else begin
        rin = rem[k-1];
        tin = rt[k-1];
        vin = val[k-1];
      end
      rs    = {rin[33:0], vin[63:62]};
      trial = {2'b00, tin, 2'b01};
      val_next[k] = {vin[61:0], 2'b00};
      if (rs >= trial) begin
        rem_next[k] = rs - trial;
        rt_next[k]  = {tin[30:0], 1'b1};
      end else begin
        rem_next[k] = rs;
        rt_next[k]  = {tin[30:0], 1'b0};
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < SQRT_STEPS; k++) begin
      rem[k] <= rem_next[k];
      rt[k]  <= rt_next[k];
      val[k] <= val_next[k];
    end
    if (rst) begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      vld[0] <= vld_in;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  assign vld_out = vld[SQRT_STEPS-1];
  assign root    = rt[SQRT_STEPS-1];

endmodule

>>> rtl/pas_div.sv
// ---------------------------------------------------------------------------
// pas_div
// three-lane pipelined restoring divider for the Q1.30 unit direction
// ---------------------------------------------------------------------------
module pas_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             vld_in,
  input  logic [31:0]      mag,
  input  logic [2:0][31:0] num,
  output logic             vld_out,
  output logic [2:0][30:0] quo
);
  import pas_pkg::*;

  logic             vld     [0:DIV_STEPS-1];
  logic [31:0]      mg      [0:DIV_STEPS-1];
  logic [2:0][31:0] r       [0:DIV_STEPS-1];
  logic [2:0][30:0] q       [0:DIV_STEPS-1];
  logic [2:0][31:0] r_next  [0:DIV_STEPS-1];
  logic [2:0][30:0] q_next  [0:DIV_STEPS-1];
  logic [31:0]      mg_next [0:DIV_STEPS-1];

  // one quotient bit per stage; the first step takes the whole numerator
  always_comb begin
    logic [32:0] rs, rn;
    logic [30:0] qi;
    logic        ge;
    for (int k = 0; k < DIV_STEPS; k++) begin
      mg_next[k] = (k == 0) ? mag : mg[k-1];
      for (int l = 0; l < 3; l++) begin
        if (k == 0) begin
          rs = {1'b0, num[l]};
          qi = 31'd0;
        end else begin
          rs = {r[k-1][l], 1'b0};
          qi = q[k-1][l];
        end
        ge = rs >= {1'b0, mg_next[k]};
        rn = ge ? rs - {1'b0, mg_next[k]} : rs;
        r_next[k][l] = rn[31:0];
        q_next[k][l] = {qi[29:0], ge};
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      mg[k] <= mg_next[k];
      r[k]  <= r_next[k];
      q[k]  <= q_next[k];
    end
    if (rst) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      vld[0] <= vld_in;
      for (int k = 1; k < DIV_STEPS; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  assign vld_out = vld[DIV_STEPS-1];
  assign quo     = q[DIV_STEPS-1];

endmodule

>>> tb/sv/pas_step_monitor.sv
// ---------------------------------------------------------------------------
// pas_step_monitor
// Watches the particle and register ports of the particle step block. It
// computes the expected updated particle for every accepted word and
// compares each done word with the oldest one waiting.
// ---------------------------------------------------------------------------
module pas_step_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        cfg_wr,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_data,
  input  logic        func,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic [31:0] speed,
  input  logic [31:0] elapsed,
  input  logic [31:0] life_limit,
  input  logic [31:0] frame_tick,
  input  logic [7:0]  frame_col,
  input  logic [7:0]  frame_row,
  input  logic [31:0] time_step,
  input  logic        done,
  input  logic [31:0] new_pos_x,
  input  logic [31:0] new_pos_y,
  input  logic [31:0] new_pos_z,
  input  logic [31:0] new_elapsed,
  input  logic [31:0] new_frame_tick,
  input  logic [7:0]  new_frame_col,
  input  logic [7:0]  new_frame_row,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pas_pkg::*;

  typedef struct {
    logic [2:0][31:0] pos;
    logic [31:0]      elapsed;
    logic [31:0]      tick;
    logic [7:0]       col;
    logic [7:0]       row;
  } particle_t;

  particle_t   expected_particles[$];
  logic [8:0]  columns_q;
  logic [8:0]  rows_q;
  logic [31:0] period_q;

  // integer square root, floor
  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [8:0] grid_size(logic [8:0] n);
    if (n == 0) return 9'd1;
    return (n > 9'd256) ? 9'd256 : n;
  endfunction

  // one particle through the radial move and the frame animation
  function automatic particle_t particle_update(logic spark, logic [2:0][31:0] p_in,
      logic [31:0] spd, logic [31:0] el, logic [31:0] life, logic [31:0] tick,
      logic [7:0] col, logic [7:0] row, logic [31:0] dt);
    particle_t   r;
    logic [63:0] ap[3];
    logic [63:0] sq, mag, au, vel, travel;
    longint      p, np;
    logic [31:0] nel, ntick;
    logic        adv;
    logic [8:0]  nc, nr;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      p = longint'($signed(p_in[i]));
      ap[i] = (p < 0) ? -p : p;
      sq += ap[i] * ap[i];
    end
    mag = root64(sq);
    for (int i = 0; i < 3; i++) begin
      p = longint'($signed(p_in[i]));
      if (mag == 0) begin
        r.pos[i] = p_in[i];
      end else begin
        au     = (ap[i] << UNIT_SHIFT) / mag;
        vel    = (au * {32'd0, spd}) >> UNIT_SHIFT;
        travel = (vel * {32'd0, dt}) >> Q_FRAC;
        np     = (p < 0) ? p - longint'(travel) : p + longint'(travel);
        if (np > 64'sd2147483647) np = 64'sd2147483647;
        if (np < -64'sd2147483648) np = -64'sd2147483648;
        r.pos[i] = np[31:0];
      end
    end
    nel   = add_sat(el, dt);
    ntick = tick;
    if (spark) begin
      ntick = add_sat(tick, dt);
      adv   = ntick > period_q;
      if (adv) ntick = 0;
      if (nel >= life) nel = 0;
    end else begin
      adv = nel >= life;
      if (adv) nel = 0;
    end
    nc = {1'b0, col};
    nr = {1'b0, row};
    if (adv) begin
      nc = nc + 1;
      if (nc >= grid_size(columns_q)) begin
        nc = 0;
        nr = nr + 1;
        if (nr >= grid_size(rows_q)) nr = 0;
      end
    end
    r.elapsed = nel;
    r.tick    = ntick;
    r.col     = nc[7:0];
    r.row     = nr[7:0];
    return r;
  endfunction

  // register shadow, word capture and comparison
  always @(posedge clk) begin
    particle_t want;
    particle_t got;
    if (rst) begin
      columns_q = COLS_RESET;
      rows_q    = ROWS_RESET;
      period_q  = PERIOD_RESET;
      expected_particles.delete();
      fails = 0;
    end else begin
      if (start && !busy)
        expected_particles.push_back(particle_update(func, {pos_z, pos_y, pos_x}, speed,
            elapsed, life_limit, frame_tick, frame_col, frame_row, time_step));
      if (done) begin
        got.pos     = {new_pos_z, new_pos_y, new_pos_x};
        got.elapsed = new_elapsed;
        got.tick    = new_frame_tick;
        got.col     = new_frame_col;
        got.row     = new_frame_row;
        if (expected_particles.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected word: pos %h %h %h", new_pos_x,
              new_pos_y, new_pos_z);
        end else begin
          want = expected_particles.pop_front();
          if (want.pos !== got.pos || want.elapsed !== got.elapsed ||
              want.tick !== got.tick || want.col !== got.col || want.row !== got.row) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch at %0t", $realtime);
              $display("  pos exp %h %h %h got %h %h %h", want.pos[0], want.pos[1],
                  want.pos[2], got.pos[0], got.pos[1], got.pos[2]);
              $display("  elapsed/tick/col/row exp %h %h %h %h got %h %h %h %h",
                  want.elapsed, want.tick, want.col, want.row,
                  got.elapsed, got.tick, got.col, got.row);
            end
          end
        end
      end
      if (cfg_wr) begin
        case (cfg_addr)
          REG_GRID_COLUMNS: columns_q = cfg_data[8:0];
          REG_GRID_ROWS:    rows_q    = cfg_data[8:0];
          REG_FRAME_PERIOD: period_q  = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_particles.size();
  end

endmodule

>>> tb/sv/tb_particle_advect_sprite_step_top.sv
// ---------------------------------------------------------------------------
// tb_particle_advect_sprite_step_top
// Drives particle words and register writes into the particle step block:
// a directed set of corner particles, then random particles under several
// grid and period settings, with random gaps in most. The monitor checks.
// ---------------------------------------------------------------------------
module tb_particle_advect_sprite_step_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pas_pkg::*;

  localparam logic       FUNC_FOG   = 1'b0;
  localparam logic       FUNC_SPARK = 1'b1;
  localparam logic [1:0] REG_NONE   = 2'd3;
  localparam int         DRAIN      = PIPE_LAT + 20;

  logic        clk, rst, start, busy, cfg_wr, func, done;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_data, pos_x, pos_y, pos_z, speed, elapsed, life_limit;
  logic [31:0] frame_tick, time_step;
  logic [7:0]  frame_col, frame_row, new_frame_col, new_frame_row;
  logic [31:0] new_pos_x, new_pos_y, new_pos_z, new_elapsed, new_frame_tick;
  int          fails, pending, word_cnt;
  logic        quiet;

  particle_advect_sprite_step_top dut (.*);
  pas_step_monitor step_mon (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("[particle_advect_sprite_step_top] ERROR");
    $finish;
  end

  // one particle word; start stays high until the next gap or quiet point
  task automatic send_word(logic f, logic [31:0] x, logic [31:0] y, logic [31:0] z,
      logic [31:0] spd, logic [31:0] el, logic [31:0] life, logic [31:0] tick,
      logic [7:0] col, logic [7:0] row, logic [31:0] dt);
    while (!quiet && $urandom_range(0, 99) < 13) begin
      start <= 1'b0;
      @(negedge clk);
    end
    while (busy) @(negedge clk);
    start <= 1'b1; func <= f; pos_x <= x; pos_y <= y; pos_z <= z; speed <= spd;
    elapsed <= el; life_limit <= life; frame_tick <= tick; frame_col <= col;
    frame_row <= row; time_step <= dt;
    @(negedge clk);
    word_cnt++;
  endtask

  // one register write; the enable is dropped after the last write of a batch
  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    cfg_wr <= 1'b1; cfg_addr <= idx; cfg_data <= v;
    @(negedge clk);
  endtask

  // quiet point: all words back and the pipe empty
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  function automatic logic [31:0] any32();
    case ($urandom_range(0, 6))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 32'h0004_0000);
      3: return $urandom() >> $urandom_range(0, 31);
      4: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // random particle, mostly near the frame-advance thresholds
  task automatic random_word(logic [8:0] cols, logic [8:0] rows, logic [31:0] period);
    logic [31:0] dt, el, life, tick;
    logic [7:0]  col, row;
    dt   = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 32'h0001_0000) : any32();
    el   = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 32'h0010_0000) : any32();
    life = ($urandom_range(0, 9) < 6) ? el + dt + $urandom_range(0, 4) - 2 : any32();
    tick = ($urandom_range(0, 9) < 6) ? period - dt + $urandom_range(0, 4) - 2 : any32();
    col  = 8'(($urandom_range(0, 9) < 8 && cols != 0) ?
        $urandom_range(0, (cols > 256 ? 256 : cols) - 1) : $urandom());
    row  = 8'(($urandom_range(0, 9) < 8 && rows != 0) ?
        $urandom_range(0, (rows > 256 ? 256 : rows) - 1) : $urandom());
    send_word($urandom_range(0, 1) ? FUNC_SPARK : FUNC_FOG, any32(), any32(), any32(),
        any32(), el, life, tick, col, row, dt);
  endtask

  initial begin
    logic [8:0]  cols[6] = '{9'd1, 9'd0, 9'd256, 9'd511, 9'd3, 9'd17};
    logic [8:0]  rows[6] = '{9'd1, 9'd0, 9'd256, 9'd300, 9'd4, 9'd2};
    logic [31:0] per[6]  = '{32'd6554, 32'd0, 32'hFFFF_FFFF, 32'h0001_0000,
                             32'h0000_8000, 32'd100};
    rst = 1; start = 0; cfg_wr = 0; cfg_addr = 0; cfg_data = 0; func = 0;
    pos_x = 0; pos_y = 0; pos_z = 0; speed = 0; elapsed = 0; life_limit = 0;
    frame_tick = 0; frame_col = 0; frame_row = 0; time_step = 0;
    word_cnt = 0; quiet = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed corners under the reset settings, then a 3x2 grid
    send_word(FUNC_FOG, 0, 0, 0, 32'hFFFF_FFFF, 5, 10, 7, 0, 0, 32'h10000);
    send_word(FUNC_FOG, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
        0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send_word(FUNC_FOG, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 255, 255, 32'hFFFF_FFFF);
    send_word(FUNC_SPARK, 32'h0001_0000, 0, 0, 32'h0002_0000, 32'hFFFF_0000,
        32'hFFFF_FFFF, 32'hFFFF_FF00, 0, 0, 32'h0001_0000);
    send_word(FUNC_SPARK, 0, 32'hFFFF_0000, 0, 32'h0001_0000, 10, 5, 6554, 0, 0, 0);
    send_word(FUNC_SPARK, 0, 0, 32'h10, 32'h0001_0000, 10, 20, 6553, 3, 7, 1);
    send_word(FUNC_FOG, 32'h1234, 32'hFFFF_EDCC, 32'h55, 32'h0003_0000, 99, 100, 1,
        200, 9, 1);
    drain();
    write_reg(REG_GRID_COLUMNS, 3);
    write_reg(REG_GRID_ROWS, 2);
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    cfg_wr <= 1'b0;
    send_word(FUNC_FOG, 1, 1, 1, 32'h0001_0000, 0, 0, 0, 1, 0, 0);
    send_word(FUNC_FOG, 1, 2, 3, 32'h0001_0000, 0, 0, 0, 2, 0, 0);
    send_word(FUNC_FOG, 1, 2, 3, 32'h0001_0000, 0, 0, 0, 2, 1, 0);
    send_word(FUNC_FOG, 1, 2, 3, 32'h0001_0000, 0, 0, 0, 9, 9, 0);
    send_word(FUNC_FOG, 1, 2, 3, 32'h0001_0000, 0, 1, 0, 9, 9, 0);
    send_word(FUNC_SPARK, 32'hFFFF_FFFF, 0, 1, 32'h0001_0000, 0, 0, 32'hFFFF_FFFF, 2, 1,
        32'hFFFF_FFFF);

    // random particles under each register setting
    quiet = 0;
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(REG_GRID_COLUMNS, {23'd0, cols[ph]});
      write_reg(REG_GRID_ROWS, {23'd0, rows[ph]});
      write_reg(REG_FRAME_PERIOD, (ph == 5) ? $urandom() : per[ph]);
      cfg_wr <= 1'b0;
      for (int n = 0; n < 135; n++) begin
        quiet = (ph == 2);
        random_word(cols[ph], rows[ph], per[ph]);
      end
    end

    drain();
    if (fails == 0)
      $display("[particle_advect_sprite_step_top] OK");
    else
      $display("[particle_advect_sprite_step_top] ERROR");
    $finish;
  end

endmodule
